@@ design/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// chm_pkg - shared types and constants
// Point format, square-root cell word and fixed limits of the chamfer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package chm_pkg;

  localparam int COORD_W = 15;
  localparam int POINT_W = 3 * COORD_W;
  localparam int SQ_W    = 32;
  localparam int ROOT_W  = 16;
  localparam int SUM_W   = 28;
  localparam int SQRT_STEPS = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // pipeline plus square-root chain depth, with margin
  localparam logic [4:0] DRAIN_CYCLES = 5'd24;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // word handed from one square-root cell to the next
  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sq_word_t;

endpackage

`default_nettype wire

@@ design/chm_cloud_mem.sv @@
// ----------------------------------------------------------------------------
// chm_cloud_mem - point store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_cloud_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire chm_pkg::point_t      wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output chm_pkg::point_t           rd_data
);

  chm_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ design/chm_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// chm_sqrt_cell - one step of the integer square root
// Tries one result bit and hands remainder and partial root onward.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire chm_pkg::sq_word_t  din,
  output chm_pkg::sq_word_t       dout
);

  localparam logic [chm_pkg::SQ_W-1:0] BIT_VAL =
    chm_pkg::SQ_W'(1) << (30 - 2 * STEP);

  logic [chm_pkg::SQ_W-1:0] trial;

  assign trial = din.res + BIT_VAL;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    if (din.rem >= trial) begin
      dout.rem <= din.rem - trial;
      dout.res <= (din.res >> 1) + BIT_VAL;
    end else begin
      dout.rem <= din.rem;
      dout.res <= din.res >> 1;
    end
  end

endmodule

`default_nettype wire

@@ design/chamfer_distance_point_clouds_unit.sv @@
// Result: after the last word the clouds are swept, and the result word is
//   registered once the output register is free; an empty cloud skips the sweep.
// Throughput: one point word a cycle while loading; no words taken from the
//   last word until the result word is registered.
// Reset: synchronous, active high; clears counts, the overflow flag and all valids.
// ----------------------------------------------------------------------------
// chamfer_distance_point_clouds_unit - symmetric chamfer distance, 3-D
// Stores two clouds, then sweeps every point against the other cloud,
// takes the floor root of each minimum and adds them with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module chamfer_distance_point_clouds_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // x[14:0], y[29:15], z[44:30], zero pad
  input  wire logic        s_tuser,   // mode: 0 first cloud, 1 second cloud
  input  wire logic        s_tlast,   // last point, compute result
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // distance_sum[27:0], zero pad
  output logic [1:0]       m_tuser    // saturated[0], dropped[1]
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_LOAD, ST_START, ST_SRC_ADDR, ST_SRC_WAIT, ST_SWEEP, ST_DRAIN, ST_FINISH
  } state_t;

  state_t state;

  logic [CW-1:0] first_count, second_count;
  logic          overflow_seen;
  logic          dir;            // 0: first -> second, 1: second -> first
  logic [CW-1:0] i_cnt, j_cnt;
  logic [4:0]    drain_cnt;
  logic [chm_pkg::SUM_W-1:0] acc;
  logic          sat_flag;

  logic [CW-1:0] ns, nd;
  assign ns = dir ? second_count : first_count;
  assign nd = dir ? first_count  : second_count;

  // ---- input word and stores ----
  chm_pkg::point_t in_pt;
  logic accept, wr_a, wr_b;

  assign in_pt    = chm_pkg::point_t'(s_tdata[chm_pkg::POINT_W-1:0]);
  assign s_tready = (state == ST_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign wr_a     = accept && !s_tuser && (first_count < CAP);
  assign wr_b     = accept &&  s_tuser && (second_count < CAP);

  logic [AW-1:0]   addr_a, addr_b;
  chm_pkg::point_t rd_a, rd_b;

  // the source store is read at i, the other at j
  assign addr_a = dir ? j_cnt[AW-1:0] : i_cnt[AW-1:0];
  assign addr_b = dir ? i_cnt[AW-1:0] : j_cnt[AW-1:0];

  chm_cloud_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_first_cloud (
    .clk(clk), .wr_en(wr_a), .wr_addr(first_count[AW-1:0]), .wr_data(in_pt),
    .rd_addr(addr_a), .rd_data(rd_a)
  );

  chm_cloud_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_second_cloud (
    .clk(clk), .wr_en(wr_b), .wr_addr(second_count[AW-1:0]), .wr_data(in_pt),
    .rd_addr(addr_b), .rd_data(rd_b)
  );

  // ---- distance pipeline ----
  chm_pkg::point_t src_pt;
  logic v0, f0, l0, d0;          // issue tags, aligned with read data
  logic v1, f1, l1;
  logic v2, f2, l2;
  logic signed [15:0] dx, dy, dz;
  logic [chm_pkg::SQ_W-1:0] sqx, sqy, sqz;
  logic [chm_pkg::SQ_W-1:0] best, cand, best_upd;
  chm_pkg::point_t dst_pt;
  chm_pkg::sq_word_t chain [chm_pkg::SQRT_STEPS+1];

  assign dst_pt   = d0 ? rd_a : rd_b;
  assign cand     = sqx + sqy + sqz;
  assign best_upd = (f2 || cand < best) ? cand : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      chain[0].valid <= 1'b0;
    end else begin
      v1 <= v0;
      v2 <= v1;
      chain[0].valid <= v2 && l2;
    end
    f1 <= f0;
    l1 <= l0;
    dx <= 16'(dst_pt.x) - 16'(src_pt.x);
    dy <= 16'(dst_pt.y) - 16'(src_pt.y);
    dz <= 16'(dst_pt.z) - 16'(src_pt.z);
    f2 <= f1;
    l2 <= l1;
    sqx <= chm_pkg::SQ_W'(dx * dx);
    sqy <= chm_pkg::SQ_W'(dy * dy);
    sqz <= chm_pkg::SQ_W'(dz * dz);
    if (v2) begin
      best <= best_upd;
    end
    chain[0].rem <= best_upd;
    chain[0].res <= '0;
  end

  // ---- square-root chain: one result bit per cell ----
  for (genvar k = 0; k < chm_pkg::SQRT_STEPS; k++) begin : g_sqrt
    chm_sqrt_cell #(.STEP(k)) u_cell (
      .clk(clk), .rst(rst), .din(chain[k]), .dout(chain[k+1])
    );
  end

  logic [chm_pkg::SUM_W:0] acc_sum;
  assign acc_sum = {1'b0, acc} +
                   (chm_pkg::SUM_W+1)'(chain[chm_pkg::SQRT_STEPS].res[chm_pkg::ROOT_W-1:0]);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      m_tvalid      <= 1'b0;
      v0            <= 1'b0;
    end else begin
      v0 <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (chain[chm_pkg::SQRT_STEPS].valid) begin
        acc <= acc_sum[chm_pkg::SUM_W] ? chm_pkg::SUM_MAX : acc_sum[chm_pkg::SUM_W-1:0];
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (wr_a) first_count <= first_count + 1'b1;
            if (wr_b) second_count <= second_count + 1'b1;
            if (!wr_a && !wr_b) overflow_seen <= 1'b1;
            if (s_tlast) state <= ST_START;
          end
        end
        ST_START: begin
          dir      <= 1'b0;
          i_cnt    <= '0;
          acc      <= '0;
          sat_flag <= 1'b0;
          if (first_count == '0 && second_count == '0) begin
            state <= ST_FINISH;
          end else if (first_count == '0 || second_count == '0) begin
            acc      <= chm_pkg::SUM_MAX;
            sat_flag <= 1'b1;
            state    <= ST_FINISH;
          end else begin
            state <= ST_SRC_ADDR;
          end
        end
        ST_SRC_ADDR: begin
          state <= ST_SRC_WAIT;
        end
        ST_SRC_WAIT: begin
          src_pt <= dir ? rd_b : rd_a;
          j_cnt  <= '0;
          state  <= ST_SWEEP;
        end
        ST_SWEEP: begin
          v0 <= 1'b1;
          f0 <= (j_cnt == '0);
          l0 <= (j_cnt == nd - 1'b1);
          d0 <= dir;
          j_cnt <= j_cnt + 1'b1;
          if (j_cnt == nd - 1'b1) begin
            if (i_cnt == ns - 1'b1) begin
              i_cnt <= '0;
              if (!dir) begin
                dir   <= 1'b1;
                state <= ST_SRC_ADDR;
              end else begin
                drain_cnt <= chm_pkg::DRAIN_CYCLES;
                state     <= ST_DRAIN;
              end
            end else begin
              i_cnt <= i_cnt + 1'b1;
              state <= ST_SRC_ADDR;
            end
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt - 1'b1;
          if (drain_cnt == '0) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            m_tdata       <= {4'b0, acc};
            m_tuser       <= {overflow_seen, sat_flag};
            first_count   <= '0;
            second_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - chamfer distance unit
// Streams point words in frames closed by tlast, works out each frame's
// chamfer sum in a local model and checks every result word against it,
// with random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------

// Keeps both clouds as they fill and the results still owed by the unit.
class chamfer_tally;
  localparam int CAP = 1024;
  localparam logic [27:0] CLAMP = 28'hFFFFFFF;

  typedef struct {
    logic [27:0] sum;
    bit          sat;
    bit          drop;
  } result_t;

  chm_pkg::point_t cloud_a[$];
  chm_pkg::point_t cloud_b[$];
  bit      lost;
  result_t sums_due[$];
  int      errors;
  int      frames;
  int      sat_seen;
  int      drop_seen;

  function longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // nearest-neighbour distances from every point of src to dst, clamped
  function longint unsigned nearest_total(chm_pkg::point_t src[$], chm_pkg::point_t dst[$]);
    longint unsigned total;
    longint unsigned best;
    longint unsigned d;
    longint dx, dy, dz;
    total = 0;
    foreach (src[i]) begin
      best = '1;
      foreach (dst[j]) begin
        dx = longint'(src[i].x) - longint'(dst[j].x);
        dy = longint'(src[i].y) - longint'(dst[j].y);
        dz = longint'(src[i].z) - longint'(dst[j].z);
        d = dx * dx + dy * dy + dz * dz;
        if (d < best) best = d;
      end
      total += root_floor(best);
      if (total > CLAMP) total = CLAMP;
    end
    return total;
  endfunction

  function void note_word(bit mode, chm_pkg::point_t p, bit last);
    result_t r;
    longint unsigned s;
    if (mode) begin
      if (cloud_b.size() < CAP) cloud_b = {cloud_b, p};
      else lost = 1;
    end else begin
      if (cloud_a.size() < CAP) cloud_a = {cloud_a, p};
      else lost = 1;
    end
    if (!last) return;
    r.sat = 0;
    if (cloud_a.size() == 0 && cloud_b.size() == 0) begin
      r.sum = 0;
    end else if (cloud_a.size() == 0 || cloud_b.size() == 0) begin
      r.sum = CLAMP;
      r.sat = 1;
    end else begin
      s = nearest_total(cloud_a, cloud_b) + nearest_total(cloud_b, cloud_a);
      if (s > CLAMP) s = CLAMP;
      r.sum = s[27:0];
    end
    r.drop = lost;
    sums_due = {sums_due, r};
    cloud_a.delete();
    cloud_b.delete();
    lost = 0;
  endfunction

  function void check_result(logic [31:0] data, logic [1:0] flags);
    result_t r;
    if (sums_due.size() == 0) begin
      $error("result word with none expected: data %h user %b", data, flags);
      errors++;
      return;
    end
    r = sums_due.pop_front();
    frames++;
    if (r.sat) sat_seen++;
    if (r.drop) drop_seen++;
    if (data[27:0] !== r.sum || data[31:28] !== 4'd0) begin
      $error("distance_sum: expected %0d, got %0d", r.sum, data);
      errors++;
    end
    if (flags[0] !== r.sat) begin
      $error("saturated: expected %0b, got %0b", r.sat, flags[0]);
      errors++;
    end
    if (flags[1] !== r.drop) begin
      $error("dropped: expected %0b, got %0b", r.drop, flags[1]);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  bit calm = 0;   // no gaps or stalls while set
  chamfer_tally tally = new();

  chamfer_distance_point_clouds_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, check on every handshake
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tally.check_result(m_tdata, m_tuser);
    m_tready <= calm || ($urandom_range(0, 99) >= 35);
  end

  task automatic send_word(bit mode, logic [14:0] x, logic [14:0] y, logic [14:0] z, bit last);
    chm_pkg::point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    while (!calm && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, z, y, x};
    s_tuser  <= mode;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tally.note_word(mode, p, last);
  endtask

  function automatic logic [14:0] pick_coord(bit wide, logic [14:0] base);
    if (wide) return 15'($urandom);
    return base + 15'($urandom_range(0, 40)) - 15'd20;
  endfunction

  // one frame of n words, mode random, tlast on the final word
  task automatic send_frame(int n, bit wide);
    logic [14:0] base;
    base = 15'($urandom);
    for (int i = 0; i < n; i++)
      send_word(1'($urandom_range(0, 1)), pick_coord(wide, base), pick_coord(wide, base),
                pick_coord(wide, base), i == n - 1);
  endtask

  initial begin
    int sent;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: lone point (one cloud empty), each mode alone
    send_word(0, 15'd5, 15'd6, 15'd7, 1);
    send_word(1, 15'h4000, 15'h4000, 15'h4000, 1);
    // opposite corners of the coordinate range
    send_word(0, 15'h4000, 15'h4000, 15'h4000, 0);
    send_word(1, 15'h3FFF, 15'h3FFF, 15'h3FFF, 1);
    send_word(1, 15'h7FFF, 15'h0000, 15'h3FFF, 0);
    send_word(0, 15'h0001, 15'h4000, 15'h7FFF, 1);
    // tie: two second-cloud points equally near the first-cloud point
    send_word(0, 15'd0, 15'd0, 15'd0, 0);
    send_word(1, 15'd3, 15'd4, 15'd0, 0);
    send_word(1, 15'h7FFD, 15'h7FFC, 15'd0, 0);
    send_word(1, 15'd0, 15'd0, 15'd12, 1);
    // coincident points give a zero sum
    send_word(1, 15'd100, 15'h7F00, 15'd9, 0);
    send_word(0, 15'd100, 15'h7F00, 15'd9, 1);

    // random frames, mostly small, a quiet stretch in the middle
    sent = 0;
    while (sent < 278) begin
      calm = (sent > 120 && sent < 170);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 48) : $urandom_range(1, 10);
      send_frame(n, 1'($urandom_range(0, 1)));
      sent += n;
    end
    calm = 0;
    s_tvalid <= 1'b0;

    while (tally.sums_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d result words (%0d with one cloud empty, %0d with dropped points),",
             tally.frames, tally.sat_seen, tally.drop_seen);
    $display("from corner and tie cases and random frames of near and far points.");
    if (tally.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
